/* hdl/palette_index_expander_core_assert.svh */
// ----------------------------------------------------------------------------
// palette index expander assertion macros
// clocked on clk, disabled while arst_n is low; empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEX_EXPANDER_CORE_ASSERT_SVH
`define PALETTE_INDEX_EXPANDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// expression holds at every edge
`define PIE_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PIE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PIE_ASSERT(lbl, expr, msg)
`define PIE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PIE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/pie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_pkg
// shared constants and types of the palette index expander
// ----------------------------------------------------------------------------
package pie_pkg;

	// palette geometry
	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// luminance weights in fixed point
	localparam int COEF_SCALE = 14;
	localparam int COEF_ONE   = 1 << COEF_SCALE;
	localparam int COEF_R     = (299 * COEF_ONE + 500) / 1000;
	localparam int COEF_G     = (587 * COEF_ONE + 500) / 1000;
	localparam int COEF_B     = COEF_ONE - COEF_R - COEF_G;
	localparam int GRAY_HALF  = 1 << (COEF_SCALE - 1);
	localparam int PROD_W     = 8 + COEF_SCALE;
	localparam int SUM_W      = PROD_W + 2;
	localparam int LUM_W      = SUM_W - COEF_SCALE;

	// index modes
	localparam logic [1:0] MODE_1BIT = 2'd0;
	localparam logic [1:0] MODE_4BIT = 2'd1;
	localparam logic [1:0] MODE_8BIT = 2'd2;

	// configuration register selects (paddr[2])
	localparam logic REG_INDEX_MODE = 1'b0;

	// action codes
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_EXPAND = 1'b1;

	// queue depths
	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// classified work entry between front and back
	typedef struct packed {
		logic              is_pixel;
		logic [7:0]        entry;
		logic [7:0]        blue;
		logic [7:0]        green;
		logic [7:0]        red;
		logic [PROD_W-1:0] prod_b;
		logic [PROD_W-1:0] prod_g;
		logic [PROD_W-1:0] prod_r;
		logic [7:0]        packed_byte;
		logic [3:0]        count;
		logic [1:0]        mode;
	} work_t;

	// one expanded pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] gray;
		logic       last;
	} pixel_t;

endpackage

/* hdl/pie_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_front
// accepts items, clamps the pixel count, forms the luminance products
// ----------------------------------------------------------------------------
module pie_front import pie_pkg::*; (
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [7:0] entry_index,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	input  logic [7:0] packed_byte,
	input  logic [3:0] pixel_count,
	input  logic [1:0] index_mode,
	input  logic       q_full,
	output logic       q_wr,
	output work_t      q_data
);

	logic [1:0] mode_n;
	logic [3:0] max_cnt;

	// mode decode, unused code behaves as eight bits
	always_comb begin
		case (index_mode)
			MODE_1BIT: begin
				mode_n  = MODE_1BIT;
				max_cnt = 4'd8;
			end
			MODE_4BIT: begin
				mode_n  = MODE_4BIT;
				max_cnt = 4'd2;
			end
			default: begin
				mode_n  = MODE_8BIT;
				max_cnt = 4'd1;
			end
		endcase
	end

	// handshake
	assign full = q_full;
	assign q_wr = push && !q_full;

	// classified entry
	always_comb begin
		q_data.is_pixel    = (action == ACT_EXPAND);
		q_data.entry       = entry_index;
		q_data.blue        = blue;
		q_data.green       = green;
		q_data.red         = red;
		q_data.prod_b      = PROD_W'(blue) * PROD_W'(COEF_B);
		q_data.prod_g      = PROD_W'(green) * PROD_W'(COEF_G);
		q_data.prod_r      = PROD_W'(red) * PROD_W'(COEF_R);
		q_data.packed_byte = packed_byte;
		q_data.count       = (pixel_count > max_cnt) ? max_cnt : pixel_count;
		q_data.mode        = mode_n;
	end

endmodule

/* hdl/pie_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_queue
// short show-ahead queue of work entries between front and back
// ----------------------------------------------------------------------------
module pie_queue import pie_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  work_t wr_data,
	input  logic  rd_en,
	output logic  full,
	output logic  empty,
	output work_t rd_data
);

	work_t            entry_q [IQ_DEPTH];
	logic [IQ_AW-1:0] wr_ptr_q;
	logic [IQ_AW-1:0] rd_ptr_q;
	logic [IQ_CW-1:0] cnt_q;

	assign full    = (cnt_q == IQ_CW'(IQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + IQ_CW'(wr_en) - IQ_CW'(rd_en);
		end
	end

endmodule

/* hdl/pie_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_back
// writes palette entries, walks packed indices, looks up and queues pixels
// ----------------------------------------------------------------------------
module pie_back import pie_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  work_t      q_head,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] pixel_blue,
	output logic [7:0] pixel_green,
	output logic [7:0] pixel_red,
	output logic [7:0] pixel_gray,
	output logic       last_pixel
);

`include "palette_index_expander_core_assert.svh"

	// palette memory: gray, red, green, blue
	logic [31:0]      pal_mem [PALETTE_DEPTH];

	logic [2:0]       pos_q;
	logic             head_load;
	logic             head_pix;
	logic             zero_cnt;
	logic             credit;
	logic             issue;
	logic             is_last;
	logic [7:0]       idx;
	logic             load_ok;
	logic             idx_ok;
	logic [SUM_W-1:0] lum_sum;
	logic [LUM_W-1:0] lum_int;
	logic [7:0]       gray;

	logic             rd_vld_s1;
	logic [31:0]      pal_rd_s1;
	logic             rd_ok_s1;
	logic             rd_last_s1;

	pixel_t           oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q;
	logic [OQ_AW-1:0] oq_rd_q;
	logic [OQ_CW-1:0] out_cnt_q;
	logic             out_pop;
	pixel_t           oq_in;

	// head classification
	assign head_load = !q_empty && !q_head.is_pixel;
	assign head_pix  = !q_empty && q_head.is_pixel;
	assign zero_cnt  = (q_head.count == 4'd0);
	assign is_last   = (({1'b0, pos_q} + 4'd1) == q_head.count);

	// a read may start only when its pixel is sure to find room
	assign credit  = ((out_cnt_q + OQ_CW'(rd_vld_s1)) < OQ_CW'(OQ_DEPTH));
	assign issue   = head_pix && !zero_cnt && credit;
	assign q_pop   = head_load || (head_pix && zero_cnt) || (issue && is_last);

	// index extraction, most significant first
	always_comb begin
		case (q_head.mode)
			MODE_1BIT: idx = {7'd0, q_head.packed_byte[3'd7 - pos_q]};
			MODE_4BIT: idx = pos_q[0] ? {4'd0, q_head.packed_byte[3:0]}
			                          : {4'd0, q_head.packed_byte[7:4]};
			default:   idx = q_head.packed_byte;
		endcase
	end

	assign load_ok = ({1'b0, q_head.entry} < 9'(PALETTE_DEPTH));
	assign idx_ok  = ({1'b0, idx} < 9'(PALETTE_DEPTH));

	// luminance: rounded sum of weighted components
	assign lum_sum = SUM_W'(q_head.prod_b) + SUM_W'(q_head.prod_g)
	               + SUM_W'(q_head.prod_r) + SUM_W'(GRAY_HALF);
	assign lum_int = lum_sum[SUM_W-1:COEF_SCALE];
	assign gray    = (lum_int > LUM_W'(255)) ? 8'hFF : lum_int[7:0];

	// palette write and registered lookup
	always_ff @(posedge clk) begin
		if (head_load && load_ok) begin
			pal_mem[q_head.entry[IDX_W-1:0]] <= {gray, q_head.red, q_head.green, q_head.blue};
		end
		if (issue) begin
			pal_rd_s1 <= pal_mem[idx[IDX_W-1:0]];
		end
	end

	// lookup side info
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_ok_s1   <= idx_ok;
			rd_last_s1 <= is_last;
		end
	end

	// run position and lookup valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	// output queue entry, out-of-range lookups read as zero
	always_comb begin
		oq_in.blue  = rd_ok_s1 ? pal_rd_s1[7:0]   : 8'd0;
		oq_in.green = rd_ok_s1 ? pal_rd_s1[15:8]  : 8'd0;
		oq_in.red   = rd_ok_s1 ? pal_rd_s1[23:16] : 8'd0;
		oq_in.gray  = rd_ok_s1 ? pal_rd_s1[31:24] : 8'd0;
		oq_in.last  = rd_last_s1;
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			oq_q[oq_wr_q] <= oq_in;
		end
	end

	// output queue pointers
	assign empty   = (out_cnt_q == '0);
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q   <= '0;
			oq_rd_q   <= '0;
			out_cnt_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + OQ_CW'(rd_vld_s1) - OQ_CW'(out_pop);
		end
	end

	// result ports
	assign pixel_blue  = oq_q[oq_rd_q].blue;
	assign pixel_green = oq_q[oq_rd_q].green;
	assign pixel_red   = oq_q[oq_rd_q].red;
	assign pixel_gray  = oq_q[oq_rd_q].gray;
	assign last_pixel  = oq_q[oq_rd_q].last;

	// checks
	`PIE_ASSERT(a_oq_bound, out_cnt_q <= OQ_CW'(OQ_DEPTH), "output queue count past depth")
	`PIE_ASSERT_IMPL(a_oq_room, rd_vld_s1, out_cnt_q < OQ_CW'(OQ_DEPTH) || out_pop, "lookup into full output queue")
	`PIE_ASSERT_IMPL(a_last_pops, issue && is_last, q_pop, "run ended without releasing its entry")
	`PIE_ASSERT_NEXT(a_pos_clear, q_pop && head_pix, pos_q == 3'd0, "run position not cleared after entry")

endmodule

/* hdl/palette_index_expander_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_index_expander_core
// expands packed palette indices into color and gray pixels
// ----------------------------------------------------------------------------
// A load item writes one palette entry and its rounded luminance and yields
// no result. A pixel item yields one result per valid pixel, one per cycle
// while the output queue has room, with its count clamped to at most 8 in
// one-bit mode, 2 in four-bit mode, 1 in eight-bit mode; the single read port
// of the palette memory serves each lookup. The first result passes through
// the work queue, the registered lookup and the output queue to the result
// ports. A four-entry queue lets input items be taken while earlier ones are
// still expanding. Program index_mode only while idle.
module palette_index_expander_core import pie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic [7:0]  packed_byte,
	input  logic [3:0]  pixel_count,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  pixel_blue,
	output logic [7:0]  pixel_green,
	output logic [7:0]  pixel_red,
	output logic [7:0]  pixel_gray,
	output logic        last_pixel
);

	logic [1:0] index_mode_q;
	logic       q_full;
	logic       q_empty;
	logic       q_wr;
	logic       q_pop;
	work_t      q_wdata;
	work_t      q_head;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mode_q <= MODE_8BIT;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_INDEX_MODE) begin
			index_mode_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_INDEX_MODE) ? {30'd0, index_mode_q} : 32'd0;

	// front end
	pie_front u_front (
		.push        (push),
		.full        (full),
		.action      (action),
		.entry_index (entry_index),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.packed_byte (packed_byte),
		.pixel_count (pixel_count),
		.index_mode  (index_mode_q),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_data      (q_wdata)
	);

	// work queue
	pie_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.rd_data (q_head)
	);

	// back end
	pie_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_blue  (pixel_blue),
		.pixel_green (pixel_green),
		.pixel_red   (pixel_red),
		.pixel_gray  (pixel_gray),
		.last_pixel  (last_pixel)
	);

endmodule
